// ----- rtl/poi_pkg.sv -----
// shared types and constants for the planar odometry integrator
package poi_pkg;

  // width of the cordic iteration index (atan table has 32 entries)
  localparam int IDX_W = 5;

  // width of one rounded position delta in nanometres
  localparam int DELTA_W = 34;

  // width of the cordic angle residue
  localparam int ANG_W = 34;

  // cordic gain, 0.6072529350 in q2.30
  localparam longint CORDIC_K_Q30 = 64'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_MUL,
    S_SAT,
    S_PUSH
  } state_t;

  // multiplier sequence; each op after OP_VFC also retires the product of the op before it
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_VFC,
    OP_VLS,
    OP_VFS,
    OP_VLC,
    OP_DX,
    OP_DY,
    OP_YAW,
    OP_HDG
  } op_t;

  typedef struct packed {
    logic             load;
    logic             rot;
    logic [IDX_W-1:0] idx;
    op_t              op;
    logic             commit;
    logic             push;
  } cmd_t;

endpackage

// ----- rtl/poi_if.sv -----
// valid/ready channel interfaces for tick input and pose output
interface poi_tick_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [23:0] yaw_rate;
  logic [15:0]        elapsed_us;

  modport source (output valid, output vel_forward, output vel_lateral,
                  output yaw_rate, output elapsed_us, input ready);
  modport sink (input valid, input vel_forward, input vel_lateral,
                input yaw_rate, input elapsed_us, output ready);
endinterface

interface poi_pose_if #(
  parameter int POS_BITS = 48
);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic [31:0]                heading_angle;
  logic                       saturated;

  modport source (output valid, output pos_x, output pos_y,
                  output heading_angle, output saturated, input ready);
  modport sink (input valid, input pos_x, input pos_y,
                input heading_angle, input saturated, output ready);
endinterface

// ----- rtl/poi_ctrl.sv -----
// sequencer: cordic iterations, multiplier op order, commit and output hand-off
module poi_ctrl import poi_pkg::*; #(
  parameter int TRIG_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam int CW = $clog2(TRIG_BITS);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  op_t           op, op_next;
  logic          out_valid_next;

  function automatic op_t succ(op_t o);
    case (o)
      OP_VFC:  succ = OP_VLS;
      OP_VLS:  succ = OP_VFS;
      OP_VFS:  succ = OP_VLC;
      OP_VLC:  succ = OP_DX;
      OP_DX:   succ = OP_DY;
      OP_DY:   succ = OP_YAW;
      OP_YAW:  succ = OP_HDG;
      default: succ = OP_HDG;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      op        <= OP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    op_next        = op;
    out_valid_next = out_valid;
    cmd            = '0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        cmd.rot = 1'b1;
        cmd.idx = IDX_W'(cnt);
        if (cnt == CW'(TRIG_BITS - 1)) begin
          op_next    = OP_VFC;
          state_next = S_MUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MUL: begin
        cmd.op = op;
        if (op == OP_HDG) begin
          op_next    = OP_IDLE;
          state_next = S_SAT;
        end else begin
          op_next = succ(op);
        end
      end
      S_SAT: begin
        cmd.commit = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // output slot free or emptying this cycle
        if (!out_valid || out_ready) begin
          cmd.push       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/poi_dpath.sv -----
// datapath: cordic sin/cos, shared mult, saturating x/y accumulators, output register
module poi_dpath import poi_pkg::*; #(
  parameter int POS_BITS  = 48,
  parameter int TRIG_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  logic signed [15:0]         vel_forward,
  input  logic signed [15:0]         vel_lateral,
  input  logic signed [23:0]         yaw_rate,
  input  logic [15:0]                elapsed_us,
  output logic signed [POS_BITS-1:0] pos_x,
  output logic signed [POS_BITS-1:0] pos_y,
  output logic [31:0]                heading_angle,
  output logic                       saturated
);

  localparam int XW = TRIG_BITS + 2;
  localparam int AW = TRIG_BITS + 17;
  localparam int PW = AW + 17;
  localparam int SW = ((POS_BITS > DELTA_W) ? POS_BITS : DELTA_W) + 1;

  localparam longint X0_FULL =
    (CORDIC_K_Q30 + (64'sd1 <<< (30 - TRIG_BITS))) >>> (31 - TRIG_BITS);
  localparam logic signed [XW-1:0] X0   = XW'(X0_FULL);
  localparam logic signed [XW-1:0] TMAX = XW'((64'sd1 <<< (TRIG_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] TMIN = XW'(-(64'sd1 <<< (TRIG_BITS - 1)));
  localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (TRIG_BITS - 2);
  localparam logic signed [SW-1:0] POS_HI = SW'({1'b0, {(POS_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] POS_LO = ~POS_HI;

  // latched tick
  logic signed [15:0] vf, vl;
  logic signed [23:0] yaw;
  logic [15:0]        dt;

  // state
  logic signed [POS_BITS-1:0] acc_x, acc_y;
  logic [31:0]                acc_heading;

  // cordic
  logic [1:0]              quad;
  logic signed [XW-1:0]    x, y;
  logic signed [ANG_W-1:0] z;
  logic [1:0]              hq;
  logic [31:0]             h_sum, h_res;
  logic signed [ANG_W-1:0] ang;

  logic signed [XW-1:0]        c_raw, s_raw, c_clp, s_clp;
  logic signed [TRIG_BITS-1:0] cos_v, sin_v;

  // multiplier and partial sums
  logic signed [AW-1:0]      mul_a;
  logic signed [16:0]        mul_b;
  logic signed [PW-1:0]      prod, rnd, rnd_sh;
  logic signed [AW-1:0]      sx, sy;
  logic signed [DELTA_W-1:0] dx, dy;

  logic signed [SW-1:0] sum_x, sum_y;
  logic                 clip;

  assign h_sum = acc_heading + 32'h2000_0000;
  assign hq    = h_sum[31:30];
  assign h_res = acc_heading - {hq, 30'd0};
  assign ang   = signed'({2'b00, ATAN_TAB[cmd.idx]});

  // quarter-turn fold then clamp to the trig range
  always_comb begin
    case (quad)
      2'd0:    begin c_raw = x;  s_raw = y;  end
      2'd1:    begin c_raw = -y; s_raw = x;  end
      2'd2:    begin c_raw = -x; s_raw = -y; end
      default: begin c_raw = y;  s_raw = -x; end
    endcase
    c_clp = (c_raw > TMAX) ? TMAX : ((c_raw < TMIN) ? TMIN : c_raw);
    s_clp = (s_raw > TMAX) ? TMAX : ((s_raw < TMIN) ? TMIN : s_raw);
    cos_v = c_clp[TRIG_BITS-1:0];
    sin_v = s_clp[TRIG_BITS-1:0];
  end

  always_comb begin
    case (cmd.op)
      OP_VFC:  begin mul_a = AW'(cos_v); mul_b = 17'(vf); end
      OP_VLS:  begin mul_a = AW'(sin_v); mul_b = 17'(vl); end
      OP_VFS:  begin mul_a = AW'(sin_v); mul_b = 17'(vf); end
      OP_VLC:  begin mul_a = AW'(cos_v); mul_b = 17'(vl); end
      OP_DX:   begin mul_a = sx;         mul_b = signed'({1'b0, dt}); end
      OP_DY:   begin mul_a = sy;         mul_b = signed'({1'b0, dt}); end
      OP_YAW:  begin mul_a = AW'(yaw);   mul_b = signed'({1'b0, dt}); end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  assign rnd    = prod + signed'(HALF);
  assign rnd_sh = rnd >>> (TRIG_BITS - 1);

  assign sum_x = SW'(acc_x) + SW'(dx);
  assign sum_y = SW'(acc_y) + SW'(dy);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vf   <= vel_forward;
      vl   <= vel_lateral;
      yaw  <= yaw_rate;
      dt   <= elapsed_us;
      quad <= hq;
      x    <= X0;
      y    <= '0;
      z    <= ANG_W'(signed'(h_res));
    end
    if (cmd.rot) begin
      if (!z[ANG_W-1]) begin
        x <= x - (y >>> cmd.idx);
        y <= y + (x >>> cmd.idx);
        z <= z - ang;
      end else begin
        x <= x + (y >>> cmd.idx);
        y <= y - (x >>> cmd.idx);
        z <= z + ang;
      end
    end
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_VLS:  sx <= prod[AW-1:0];
      OP_VFS:  sx <= sx - prod[AW-1:0];
      OP_VLC:  sy <= prod[AW-1:0];
      OP_DX:   sy <= sy + prod[AW-1:0];
      OP_DY:   dx <= rnd_sh[DELTA_W-1:0];
      OP_YAW:  dy <= rnd_sh[DELTA_W-1:0];
      default: ;
    endcase
    if (cmd.commit) begin
      clip <= (sum_x > POS_HI) || (sum_x < POS_LO) ||
              (sum_y > POS_HI) || (sum_y < POS_LO);
    end
    if (cmd.push) begin
      pos_x         <= acc_x;
      pos_y         <= acc_y;
      heading_angle <= acc_heading;
      saturated     <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      if (cmd.op == OP_HDG) acc_heading <= acc_heading + prod[31:0];
      if (cmd.commit) begin
        acc_x <= (sum_x > POS_HI) ? POS_HI[POS_BITS-1:0] :
                 (sum_x < POS_LO) ? POS_LO[POS_BITS-1:0] : sum_x[POS_BITS-1:0];
        acc_y <= (sum_y > POS_HI) ? POS_HI[POS_BITS-1:0] :
                 (sum_y < POS_LO) ? POS_LO[POS_BITS-1:0] : sum_y[POS_BITS-1:0];
      end
    end
  end

endmodule

// ----- rtl/planar_odometry_integrator.sv -----
// top level of the planar odometry integrator
//
//   channel  dir  handshake      payload
//   tick     in   valid/ready    vel_forward, vel_lateral, yaw_rate, elapsed_us
//   pose     out  valid/ready    pos_x, pos_y, heading_angle, saturated
//
// pose valid follows an accepted tick after TRIG_BITS cordic iterations, eight passes
// through the shared multiplier, one saturating commit and the load of the output
// register; the sequencer then returns to idle before it takes the next tick.
// tick.ready is high only while the sequencer is idle; the pose register holds its beat
// until taken, one more tick is worked while it waits and then stalls at the hand-off.
// reset clears position and heading to zero and empties the output register.
module planar_odometry_integrator import poi_pkg::*; #(
  parameter int POS_BITS  = 48,
  parameter int TRIG_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  poi_tick_if.sink   tick,
  poi_pose_if.source pose
);

  cmd_t cmd;

  poi_ctrl #(
    .TRIG_BITS (TRIG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .cmd       (cmd)
  );

  poi_dpath #(
    .POS_BITS  (POS_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .vel_forward   (tick.vel_forward),
    .vel_lateral   (tick.vel_lateral),
    .yaw_rate      (tick.yaw_rate),
    .elapsed_us    (tick.elapsed_us),
    .pos_x         (pose.pos_x),
    .pos_y         (pose.pos_y),
    .heading_angle (pose.heading_angle),
    .saturated     (pose.saturated)
  );

endmodule

// ----- rtl/poi_checker.sv -----
// port-level checks for the planar odometry integrator, bound to the top level
module poi_checker #(
  parameter int POS_BITS = 48
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [POS_BITS-1:0] pos_x,
  input logic [POS_BITS-1:0] pos_y,
  input logic [31:0]         heading_angle,
  input logic                saturated
);

  localparam logic [POS_BITS-1:0] P_HI = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic [POS_BITS-1:0] P_LO = {1'b1, {(POS_BITS-1){1'b0}}};

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pose valid after reset");

  // the sequencer is busy for the cycle after it takes a tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("tick accepted on consecutive cycles");

  // a clipped beat must sit on a position limit
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (pos_x == P_HI) || (pos_x == P_LO) || (pos_y == P_HI) || (pos_y == P_LO))
    else $error("saturated set with both positions inside range");

  // stalled pose beat holds
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(pos_x) && $stable(pos_y) &&
      $stable(heading_angle) && $stable(saturated))
    else $error("pose beat changed while stalled");

endmodule

bind planar_odometry_integrator poi_checker #(
  .POS_BITS (POS_BITS)
) u_poi_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (tick.valid),
  .in_ready      (tick.ready),
  .out_valid     (pose.valid),
  .out_ready     (pose.ready),
  .pos_x         (pose.pos_x),
  .pos_y         (pose.pos_y),
  .heading_angle (pose.heading_angle),
  .saturated     (pose.saturated)
);
